// ===== rtl/core/bcp_pkg.sv =====
// Shared types, constants and saturation helpers for the box collision push-out block.
// No dependencies; every other file in rtl/core imports this package.
package bcp_pkg;

  localparam int CW    = 32;
  localparam int HW    = CW - 1;
  localparam int AW    = CW + 1;
  localparam int SW    = CW + 2;
  localparam int SQ_W  = 2 * CW;
  localparam int ROOT_W = CW;
  localparam int NUM_W = 2 * CW - 1;
  localparam int Q_W   = CW;

  localparam int SQ_STAGES  = ROOT_W;
  localparam int DIV_STAGES = Q_W;
  localparam int I_SQ   = 1;
  localparam int I_PROD = I_SQ + SQ_STAGES + 1;
  localparam int I_NUM  = I_PROD + 1;
  localparam int I_OUT  = I_NUM + DIV_STAGES + 1;
  localparam int LAT    = I_OUT + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z   = 3'd5;

  localparam logic REQ_BOX    = 1'b0;
  localparam logic REQ_SPHERE = 1'b1;

  localparam logic signed [SW-1:0] SAT_HI = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {3'b111, {(CW-1){1'b0}}};
  localparam logic [AW-1:0] SHIFT_LIM = {2'b01, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic [2:0][HW-1:0] half;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [2:0][CW-1:0] center;
    logic [2:0][HW-1:0] half;
    logic [HW-1:0]      radius;
  } req_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic               direct;
    logic               hit;
    logic               flag;
    logic [2:0]         neg;
    logic [2:0][CW-1:0] pos;
    logic [2:0][CW-1:0] a_s;
    logic [HW-1:0]      r;
    logic [HW-1:0]      rs;
    logic               m_gt_r;
  } item_t;

  function automatic logic [CW-1:0] sat_val(input logic signed [SW-1:0] x);
    if (x > SAT_HI) return {1'b0, {HW{1'b1}}};
    else if (x < SAT_LO) return {1'b1, {HW{1'b0}}};
    else return x[CW-1:0];
  endfunction

  function automatic logic sat_ovf(input logic signed [SW-1:0] x);
    return (x > SAT_HI) || (x < SAT_LO);
  endfunction

endpackage

// ===== rtl/core/bcp_sqrt.sv =====
// Pipelined integer square root (floor), one result bit per stage.
// Depends on bcp_pkg.
module bcp_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [bcp_pkg::SQ_W-1:0]     x_i,
  output logic [bcp_pkg::ROOT_W-1:0]   root_o
);
  import bcp_pkg::*;

  localparam int RW = ROOT_W + 4;

  logic [RW-1:0]     rem_q  [SQ_STAGES-1];
  logic [SQ_W-1:0]   x_q    [SQ_STAGES-1];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    logic [RW-1:0]     rem_in, cur, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   x_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    assign cur   = {rem_in[RW-3:0], x_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (k < SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? cur - trial : cur;
          x_q[k]   <= {x_in[SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

// ===== rtl/core/bcp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bcp_pkg; the quotient must fit in Q_W bits.
module bcp_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [bcp_pkg::NUM_W-1:0]   n_i,
  input  logic [bcp_pkg::ROOT_W-1:0]  d_i,
  output logic [bcp_pkg::Q_W-1:0]     q_o
);
  import bcp_pkg::*;

  logic [ROOT_W-1:0]     rem_q [DIV_STAGES-1];
  logic [DIV_STAGES-1:0] lo_q  [DIV_STAGES-1];
  logic [ROOT_W-1:0]     d_q   [DIV_STAGES-1];
  logic [Q_W-1:0]        q_q   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    logic [ROOT_W-1:0]     rem_in, d_in;
    logic [DIV_STAGES-1:0] lo_in;
    logic [Q_W-1:0]        q_in;
    logic [ROOT_W:0]       cur, diff;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in = ROOT_W'(n_i[NUM_W-1:DIV_STAGES]);
      assign lo_in  = n_i[DIV_STAGES-1:0];
      assign d_in   = d_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign d_in   = d_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign cur  = {rem_in, lo_in[DIV_STAGES-1]};
    assign diff = cur - {1'b0, d_in};
    assign ge   = cur >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k] <= {q_in[Q_W-2:0], ge};
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[ROOT_W-1:0] : cur[ROOT_W-1:0];
          lo_q[k]  <= {lo_in[DIV_STAGES-2:0], 1'b0};
          d_q[k]   <= d_in;
        end
      end
    end
  end

  assign q_o = q_q[DIV_STAGES-1];

endmodule

// ===== rtl/core/bcp_front.sv =====
// Front end: configuration registers, request intake and classification.
// Box results are finished here; sphere items get offsets for the back end. Depends on bcp_pkg.
module bcp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bcp_pkg::CW-1:0]          cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  bcp_pkg::req_t                   req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bcp_pkg::item_t                  out_o
);
  import bcp_pkg::*;

  typedef struct packed {
    logic               sphere;
    logic [HW-1:0]      r;
    logic [2:0][CW-1:0] bc;
    logic [2:0][CW-1:0] oc;
    logic [2:0][AW-1:0] d;
    logic [2:0][HW-1:0] s;
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
    logic               fs;
    logic               fb;
  } stage_a_t;

  cfg_t     cfg_q;
  stage_a_t a_d, a_q;
  item_t    b_d, b_q;
  logic     va_q, vb_q, en;

  logic [CW-1:0] sumh [3];
  logic [SW-1:0] low [3], high [3];

  logic [AW-1:0] ab [3], as [3], dd [3];
  logic [CW-1:0] c [3];
  logic [SW-1:0] loc [3], bsum [3];
  logic [AW-1:0] far, m;
  logic          hit_b, fo, zero, sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X: cfg_q.center[0] <= cfg_data_i;
        CFG_CENTER_Y: cfg_q.center[1] <= cfg_data_i;
        CFG_CENTER_Z: cfg_q.center[2] <= cfg_data_i;
        CFG_HALF_X:   cfg_q.half[0]   <= cfg_data_i[HW-1:0];
        CFG_HALF_Y:   cfg_q.half[1]   <= cfg_data_i[HW-1:0];
        CFG_HALF_Z:   cfg_q.half[2]   <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  assign en     = !vb_q || out_ready_i;
  assign full_o = !en;

  always_comb begin
    a_d        = '0;
    a_d.sphere = (req_i.kind == REQ_SPHERE);
    a_d.r      = req_i.radius;
    for (int i = 0; i < 3; i++) begin
      a_d.oc[i] = req_i.center[i];
      a_d.bc[i] = cfg_q.center[i];
      a_d.d[i]  = {req_i.center[i][CW-1], req_i.center[i]}
                - {cfg_q.center[i][CW-1], cfg_q.center[i]};
      sumh[i]   = {1'b0, cfg_q.half[i]} + {1'b0, req_i.half[i]};
      a_d.s[i]  = sumh[i][CW-1] ? {HW{1'b1}} : sumh[i][HW-1:0];
      low[i]    = {{2{cfg_q.center[i][CW-1]}}, cfg_q.center[i]} - {3'b000, cfg_q.half[i]};
      high[i]   = {{2{cfg_q.center[i][CW-1]}}, cfg_q.center[i]} + {3'b000, cfg_q.half[i]};
      a_d.lo[i] = sat_val(low[i]);
      a_d.hi[i] = sat_val(high[i]);
      a_d.fs    = a_d.fs | sumh[i][CW-1];
      a_d.fb    = a_d.fb | sat_ovf(low[i]) | sat_ovf(high[i]);
    end
  end

  always_comb begin
    b_d   = '0;
    hit_b = 1'b1;
    fo    = 1'b0;
    far   = '0;
    m     = '0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = a_q.d[i][AW-1] ? -a_q.d[i] : a_q.d[i];
      if (ab[i] > {2'b00, a_q.s[i]}) hit_b = 1'b0;
      if (ab[i] > far) far = ab[i];
      if ($signed(a_q.oc[i]) < $signed(a_q.lo[i])) c[i] = a_q.lo[i];
      else if ($signed(a_q.oc[i]) > $signed(a_q.hi[i])) c[i] = a_q.hi[i];
      else c[i] = a_q.oc[i];
      dd[i] = {a_q.oc[i][CW-1], a_q.oc[i]} - {c[i][CW-1], c[i]};
      as[i] = dd[i][AW-1] ? -dd[i] : dd[i];
      if (as[i] > m) m = as[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (ab[i] <= {2'b00, a_q.s[i]} && ab[i] == far) begin
        if (a_q.d[i][AW-1]) loc[i] = -{3'b000, a_q.s[i]};
        else if (a_q.d[i] != '0) loc[i] = {3'b000, a_q.s[i]};
        else loc[i] = '0;
      end else begin
        loc[i] = {a_q.d[i][AW-1], a_q.d[i]};
      end
      bsum[i] = {{2{a_q.bc[i][CW-1]}}, a_q.bc[i]} + loc[i];
      fo      = fo | sat_ovf(bsum[i]);
    end
    zero       = (m == '0);
    sh         = m > SHIFT_LIM;
    b_d.direct = !a_q.sphere || zero;
    b_d.hit    = a_q.sphere ? 1'b1 : hit_b;
    b_d.flag   = a_q.sphere ? a_q.fb : (a_q.fs | fo);
    b_d.r      = a_q.r;
    b_d.rs     = sh ? {1'b0, a_q.r[HW-1:1]} : a_q.r;
    b_d.m_gt_r = m > {2'b00, a_q.r};
    for (int i = 0; i < 3; i++) begin
      b_d.pos[i] = a_q.sphere ? c[i] : sat_val(bsum[i]);
      b_d.neg[i] = dd[i][AW-1];
      b_d.a_s[i] = sh ? as[i][AW-1:1] : as[i][CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= push_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_o       = b_q;

endmodule

// ===== rtl/core/bcp_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on bcp_pkg.
module bcp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bcp_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bcp_pkg::item_t data_o
);
  import bcp_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/bcp_back.sv =====
// Back end: sphere push-out pipeline (squares, square root, scaling divide) and result register.
// Depends on bcp_pkg, bcp_sqrt and bcp_div.
module bcp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bcp_pkg::item_t                 in_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic                           hit_o,
  output logic [2:0][bcp_pkg::CW-1:0]    fix_o,
  output logic                           sat_o
);
  import bcp_pkg::*;

  logic [LAT-1:0]    v_q;
  item_t             sb_q [I_OUT];
  item_t             sb1_d;
  logic              adv;

  logic [SQ_W-1:0]   sqa_q [3];
  logic [SQ_W-3:0]   rr_q;
  logic [SQ_W-1:0]   sq_q;
  logic [ROOT_W-1:0] root, len_q, len2_q;
  logic [NUM_W-1:0]  prod_q [3], num_q [3];
  logic [Q_W-1:0]    q [3];

  logic [SW-1:0]     off [3], fsum [3];
  logic              fo;
  logic [2:0][CW-1:0] fix_d;

  logic              hit_q, sat_q;
  logic [2:0][CW-1:0] fix_q;

  assign adv        = !v_q[LAT-1] || pop_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  always_comb begin
    sb1_d = sb_q[0];
    if (!sb_q[0].direct) begin
      sb1_d.hit = !sb_q[0].m_gt_r
                && (sqa_q[0] + sqa_q[1] + sqa_q[2] <= {2'b00, rr_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= in_i;
      for (int i = 0; i < 3; i++) begin
        sqa_q[i] <= SQ_W'(in_i.a_s[i]) * SQ_W'(in_i.a_s[i]);
      end
      rr_q    <= (SQ_W-2)'(in_i.rs) * (SQ_W-2)'(in_i.rs);
      sb_q[1] <= sb1_d;
      sq_q    <= sqa_q[0] + sqa_q[1] + sqa_q[2];
      for (int k = 2; k < I_OUT; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
      len_q  <= root;
      len2_q <= len_q;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= NUM_W'(sb_q[I_PROD-1].r) * NUM_W'(sb_q[I_PROD-1].a_s[i]);
        num_q[i]  <= prod_q[i] + NUM_W'(len_q[ROOT_W-1:1]);
      end
    end
  end

  bcp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (sq_q),
    .root_o (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    bcp_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .n_i   (num_q[i]),
      .d_i   (len2_q),
      .q_o   (q[i])
    );
  end

  always_comb begin
    fo = 1'b0;
    for (int i = 0; i < 3; i++) begin
      off[i]  = sb_q[I_OUT-1].neg[i] ? -{2'b00, q[i]} : {2'b00, q[i]};
      fsum[i] = {{2{sb_q[I_OUT-1].pos[i][CW-1]}}, sb_q[I_OUT-1].pos[i]} + off[i];
      fo      = fo | sat_ovf(fsum[i]);
      fix_d[i] = sb_q[I_OUT-1].direct ? sb_q[I_OUT-1].pos[i] : sat_val(fsum[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= sb_q[I_OUT-1].hit;
      sat_q <= sb_q[I_OUT-1].flag | (!sb_q[I_OUT-1].direct & fo);
      fix_q <= fix_d;
    end
  end

  assign empty_o = !v_q[LAT-1];
  assign hit_o   = hit_q;
  assign sat_o   = sat_q;
  assign fix_o   = fix_q;

endmodule

// ===== rtl/core/box_collision_push_out.sv =====
// Top level of the box collision push-out block.
// Depends on bcp_pkg, bcp_front, bcp_fifo and bcp_back.
//
// Usage:
//   Write the own box (center x/y/z, half extents x/y/z) through cfg_we_i,
//   cfg_idx_i and cfg_data_i while no request is in flight; all six
//   registers reset to zero.
//   Requests enter like a queue write: a transfer happens on a clock edge
//   with push high and full low. Results leave like a queue read: the oldest
//   result sits on the result ports while empty is low and transfers on an
//   edge with pop high.
//   Throughput is one request per cycle while full stays low; every request yields one result.
//   A request passes through two front stages, one queue slot and a 69-stage
//   back end set by the 32-stage square root and 32-stage divider.
//   When the receiver stalls, the back end holds, a four-entry queue fills,
//   then the front end holds and full rises. Reset empties everything.
module box_collision_push_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcp_pkg::CW-1:0]         cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type_i,
  input  logic [bcp_pkg::CW-1:0]         other_center_x_i,
  input  logic [bcp_pkg::CW-1:0]         other_center_y_i,
  input  logic [bcp_pkg::CW-1:0]         other_center_z_i,
  input  logic [bcp_pkg::HW-1:0]         other_half_x_i,
  input  logic [bcp_pkg::HW-1:0]         other_half_y_i,
  input  logic [bcp_pkg::HW-1:0]         other_half_z_i,
  input  logic [bcp_pkg::HW-1:0]         sphere_radius_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           hit_o,
  output logic [bcp_pkg::CW-1:0]         fix_x_o,
  output logic [bcp_pkg::CW-1:0]         fix_y_o,
  output logic [bcp_pkg::CW-1:0]         fix_z_o,
  output logic                           saturated_o
);
  import bcp_pkg::*;

  req_t               req;
  item_t              f_item, q_item;
  logic               f_valid, q_full, q_empty, b_ready;
  logic [2:0][CW-1:0] fix;

  assign req.kind      = req_type_i;
  assign req.center[0] = other_center_x_i;
  assign req.center[1] = other_center_y_i;
  assign req.center[2] = other_center_z_i;
  assign req.half[0]   = other_half_x_i;
  assign req.half[1]   = other_half_y_i;
  assign req.half[2]   = other_half_z_i;
  assign req.radius    = sphere_radius_i;

  bcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req),
    .out_valid_o (f_valid),
    .out_ready_i (!q_full),
    .out_o       (f_item)
  );

  bcp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (b_ready),
    .empty_o (q_empty),
    .data_o  (q_item)
  );

  bcp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_ready_o (b_ready),
    .in_i       (q_item),
    .empty_o    (empty),
    .pop_i      (pop),
    .hit_o      (hit_o),
    .fix_o      (fix),
    .sat_o      (saturated_o)
  );

  assign fix_x_o = fix[0];
  assign fix_y_o = fix[1];
  assign fix_z_o = fix[2];

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for box_collision_push_out: box-box and box-sphere requests
// are checked against a bit-exact predictor over several own-box settings.
// Depends on bcp_pkg and the box_collision_push_out RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcp_pkg::*;

  localparam int TAIL  = LAT + 10;
  localparam int LIMIT = 600000;

  typedef struct {
    logic        hit;
    logic [31:0] fix [3];
    logic        sat;
  } push_out_t;

  class push_out_scoreboard;
    longint    own_c [3];
    longint    own_h [3];
    push_out_t pend [$];
    int        errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        own_c[i] = 0;
        own_h[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      if (idx <= CFG_CENTER_Z) own_c[idx] = longint'($signed(v));
      else own_h[idx - CFG_HALF_X] = longint'({1'b0, v[30:0]});
    endfunction

    function longint clip(longint v, inout bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned res, t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if (128'(t) * 128'(t) <= 128'(x)) res = t;
      end
      return res;
    endfunction

    function push_out_t predict(req_t q);
      push_out_t o;
      longint oc [3], d [3], c [3], res [3], s [3];
      longint unsigned a [3];
      longint lo, hi, loc;
      longint unsigned far, m, sq, len, qr, rr, rs, qv, r;
      int sh;
      bit flag, hit;
      flag = 0;
      hit = 1;
      r = q.radius;
      for (int i = 0; i < 3; i++) oc[i] = longint'($signed(q.center[i]));
      if (q.kind == REQ_BOX) begin
        far = 0;
        for (int i = 0; i < 3; i++) begin
          s[i] = clip(own_h[i] + longint'({1'b0, q.half[i]}), flag);
          d[i] = oc[i] - own_c[i];
          a[i] = d[i] < 0 ? -d[i] : d[i];
          if (a[i] > longint'(s[i])) hit = 0;
          if (a[i] > far) far = a[i];
        end
        for (int i = 0; i < 3; i++) begin
          loc = d[i];
          if (a[i] <= s[i] && a[i] == far) loc = d[i] > 0 ? s[i] : (d[i] < 0 ? -s[i] : 0);
          res[i] = clip(own_c[i] + loc, flag);
        end
      end else begin
        m = 0;
        for (int i = 0; i < 3; i++) begin
          lo = clip(own_c[i] - own_h[i], flag);
          hi = clip(own_c[i] + own_h[i], flag);
          c[i] = oc[i] < lo ? lo : (oc[i] > hi ? hi : oc[i]);
          d[i] = oc[i] - c[i];
          a[i] = d[i] < 0 ? -d[i] : d[i];
          if (a[i] > m) m = a[i];
        end
        if (m == 0) begin
          for (int i = 0; i < 3; i++) res[i] = c[i];
        end else begin
          sh = 0;
          sq = 0;
          while ((m >> sh) > (64'd1 << 31)) sh++;
          for (int i = 0; i < 3; i++) begin
            a[i] = a[i] >> sh;
            sq += a[i] * a[i];
          end
          if (m > r) hit = 0;
          else begin
            rs = r >> sh;
            hit = sq <= rs * rs;
          end
          len = root(sq);
          qr = r / len;
          rr = r % len;
          for (int i = 0; i < 3; i++) begin
            qv = qr * a[i] + (rr * a[i] + (len >> 1)) / len;
            res[i] = clip(c[i] + (d[i] < 0 ? -longint'(qv) : longint'(qv)), flag);
          end
        end
      end
      o.hit = hit;
      o.sat = flag;
      for (int i = 0; i < 3; i++) o.fix[i] = res[i][31:0];
      return o;
    endfunction

    function void note(req_t q);
      pend.push_back(predict(q));
    endfunction

    function void check(push_out_t got);
      push_out_t e;
      if (pend.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pend.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d got %0d", e.hit, got.hit);
        errors++;
      end
      for (int i = 0; i < 3; i++)
        if (got.fix[i] !== e.fix[i]) begin
          $error("fix_%s: expected %h got %h", i == 0 ? "x" : (i == 1 ? "y" : "z"),
                 e.fix[i], got.fix[i]);
          errors++;
        end
      if (got.sat !== e.sat) begin
        $error("saturated: expected %0d got %0d", e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0] cfg_data_i;
  logic push, full, empty, pop;
  logic req_type_i;
  logic [CW-1:0] other_center_x_i, other_center_y_i, other_center_z_i;
  logic [HW-1:0] other_half_x_i, other_half_y_i, other_half_z_i, sphere_radius_i;
  logic hit_o, saturated_o;
  logic [CW-1:0] fix_x_o, fix_y_o, fix_z_o;

  push_out_scoreboard sb = new();
  int cycles = 0;
  int popped = 0;

  box_collision_push_out u_dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    push_out_t got;
    if (rst_ni && pop && !empty) begin
      got.hit = hit_o;
      got.fix[0] = fix_x_o;
      got.fix[1] = fix_y_o;
      got.fix[2] = fix_z_o;
      got.sat = saturated_o;
      sb.check(got);
      popped++;
    end
  end

  // receiver: stall patterns chosen at random, one long hold-off once
  initial begin
    int mode;
    bit held;
    pop = 0;
    held = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (!held && popped >= 300) begin
        held = 1;
        pop = 0;
        repeat (400) @(negedge clk_i);
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: pop = 1;
        1: pop = $urandom_range(0, 3) != 0;
        2: pop = $urandom_range(0, 1);
        default: pop = $urandom_range(0, 5) == 0;
      endcase
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_box(logic [31:0] cx, cy, cz, logic [30:0] hx, hy, hz);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_HALF_X, {1'b0, hx});
    write_reg(CFG_HALF_Y, {1'b0, hy});
    write_reg(CFG_HALF_Z, {1'b0, hz});
  endtask

  task automatic drain();
    push = 0;
    wait (sb.pend.size() == 0);
    repeat (TAIL) @(posedge clk_i);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(req_t q);
    push = 1;
    req_type_i = q.kind;
    other_center_x_i = q.center[0];
    other_center_y_i = q.center[1];
    other_center_z_i = q.center[2];
    other_half_x_i = q.half[0];
    other_half_y_i = q.half[1];
    other_half_z_i = q.half[2];
    sphere_radius_i = q.radius;
    do @(posedge clk_i); while (full);
    sb.note(q);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] offset();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom_range(0, 511) - 256;
      2: return $urandom_range(0, 1 << 21) - (1 << 20);
      3: return $urandom_range(0, 1 << 25) - (1 << 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] extent();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 1 << 20);
      2: return $urandom_range(0, 1 << 26);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.kind = $urandom_range(0, 1) ? REQ_SPHERE : REQ_BOX;
    for (int i = 0; i < 3; i++) begin
      q.center[i] = $urandom_range(0, 7) == 0 ? $urandom
                                               : sb.own_c[i][31:0] + offset();
      q.half[i] = extent();
    end
    q.radius = extent();
    return q;
  endfunction

  function automatic req_t mk(logic k, logic [31:0] c, logic [30:0] h, logic [30:0] r);
    req_t q;
    q.kind = k;
    for (int i = 0; i < 3; i++) begin
      q.center[i] = c;
      q.half[i] = h;
    end
    q.radius = r;
    return q;
  endfunction

  initial begin
    req_t dir [$];
    req_t q;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = CFG_CENTER_X;
    cfg_data_i = 0;
    push = 0;
    req_type_i = REQ_BOX;
    other_center_x_i = 0;
    other_center_y_i = 0;
    other_center_z_i = 0;
    other_half_x_i = 0;
    other_half_y_i = 0;
    other_half_z_i = 0;
    sphere_radius_i = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed, own box at reset (origin, zero size)
    dir.push_back(mk(REQ_BOX, 0, 0, 0));
    dir.push_back(mk(REQ_BOX, 32'h7fffffff, 31'h7fffffff, 0));
    dir.push_back(mk(REQ_BOX, 32'h80000000, 31'h7fffffff, 0));
    dir.push_back(mk(REQ_BOX, 32'h00010000, 0, 0));
    dir.push_back(mk(REQ_SPHERE, 0, 0, 0));
    dir.push_back(mk(REQ_SPHERE, 32'h00010000, 0, 31'h0001bbbb));
    dir.push_back(mk(REQ_SPHERE, 32'h80000000, 0, 31'h7fffffff));
    dir.push_back(mk(REQ_SPHERE, 32'h7fffffff, 0, 31'h7fffffff));
    q = mk(REQ_SPHERE, 0, 0, 31'd5);
    q.center[0] = 3;
    q.center[1] = 32'hfffffffc;
    dir.push_back(q);
    q.radius = 4;
    dir.push_back(q);
    q = mk(REQ_BOX, 0, 31'd10, 0);
    q.center[0] = 10;
    q.center[1] = 32'hfffffff6;
    q.center[2] = 3;
    dir.push_back(q);
    q.center[2] = 11;
    dir.push_back(q);
    foreach (dir[i]) send(dir[i]);
    drain();

    set_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    for (int i = 0; i < 6; i++) send(rand_req());
    drain();
    set_box(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0);
    for (int i = 0; i < 6; i++) send(rand_req());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_box(32'h00020000, 32'hfffe0000, 0, 31'h00010000, 31'h00008000, 31'h00030000);
        1: set_box(32'h7fff0000, 32'h80010000, 32'h00100000,
                   31'h7fffffff, 31'h00100000, 0);
        2: set_box($urandom, $urandom, $urandom, extent(), extent(), extent());
        3: set_box(0, 0, 0, 0, 0, 0);
        4: set_box(32'h80000000, 32'h7fffffff, 0, 31'h00001000, 31'h7fffffff, 31'h00000100);
        default: set_box($urandom_range(0, 1 << 24), $urandom, 32'hffff0000,
                         extent(), extent(), extent());
      endcase
      for (int n = 0; n < 270;) begin
        int burst;
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && n < 270; b++, n++) send(rand_req());
        if ($urandom_range(0, 2) != 0) begin
          push = 0;
          repeat ($urandom_range(1, 12)) @(negedge clk_i);
        end
      end
      drain();
    end

    if (sb.pend.size() != 0) begin
      $error("%0d results never arrived", sb.pend.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
